// File: sv/eetg_pkg.sv
`default_nettype none
package eetg_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int MEAN_W     = 20;
    localparam int GAP_W      = 20;
    localparam int COUNT_W    = 13;
    localparam int TIME_W     = 32;
    localparam int LFSR_W     = 16;
    localparam int ADDR_W     = 16;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 13;
    localparam int CHAN_W     = 2;
    localparam int EXP_W      = 4;
    localparam int L2_W       = EXP_W + LFSR_W;
    localparam int LN_W       = 20;
    localparam int MANT_W     = 32;
    localparam int PROD_W     = MEAN_W + LN_W;

    localparam logic [1:0] REG_MEAN  = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_START = 2'd3;

    localparam logic [MEAN_W-1:0]  MEAN_RESET  = 20'd1000;
    localparam logic [GAP_W-1:0]   MIN_RESET   = 20'd100;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
    localparam logic [TIME_W-1:0]  START_RESET = 32'd1000000;

    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_FULL  = 16'hFFFF;
    localparam logic [ADDR_W-1:0] BLOCK_STEP = 16'h0100;
    localparam logic [ADDR_W-1:0] BLOCK_LAST = 16'hC600;
    localparam logic [15:0]       LN2_Q16    = 16'd45426;
    localparam int                FRAC_BITS  = 16;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_interval;
        logic [GAP_W-1:0]   min_gap;
        logic [COUNT_W-1:0] event_count;
        logic               start_load;
        logic [TIME_W-1:0]  start_time;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic drawing;
    } back_status_t;

    // elaboration-time ln in q4.16, same arithmetic as the draw engine
    function automatic logic [LN_W-1:0] ln_q16(input logic [LFSR_W-1:0] x);
        logic [EXP_W-1:0]  e;
        logic [63:0]       m;
        logic [FRAC_BITS-1:0] frac;
        logic [35:0]       p;
        e = '0;
        frac = '0;
        for (int i = 0; i < LFSR_W; i++)
        begin
            if (x[i])
                e = EXP_W'(i);
        end
        m = 64'(x) << (30 - int'(e));
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> 30;
            frac = {frac[FRAC_BITS-2:0], 1'b0};
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        p = 36'({e, frac}) * 36'(LN2_Q16) + 36'd32768;
        return p[35:16];
    endfunction

    localparam logic [LN_W-1:0] LN_FULL = ln_q16(LFSR_FULL);

endpackage
`default_nettype wire

// File: sv/eetg_front.sv
`default_nettype none
module eetg_front #(
    parameter int NUM_CHANNELS = 3,
    parameter int CH_W = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [eetg_pkg::CHAN_W-1:0]   channel,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output logic [CH_W-1:0]                    q_ch
);

    logic [CH_W-1:0] mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            in_range;
    logic            push;
    logic            pop;

    assign in_range = (32'(channel) < NUM_CHANNELS);
    assign in_ready = (count_reg != 2'd2);
    // out-of-range channels are taken and dropped
    assign push     = in_valid && in_ready && in_range;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_ch     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= CH_W'(channel);
    end

endmodule
`default_nettype wire

// File: sv/eetg_back.sv
`default_nettype none
module eetg_back #(
    parameter int NUM_CHANNELS = 3,
    parameter int MAX_DRAWS = 64,
    parameter int MAX_EVENTS = 4096,
    parameter int CH_W = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire eetg_pkg::cfg_t                   cfg,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire logic [CH_W-1:0]                  q_ch,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [eetg_pkg::TIME_W-1:0]           timestamp,
    output logic [eetg_pkg::ADDR_W-1:0]           first_block_address,
    output logic [eetg_pkg::ADDR_W-1:0]           second_block_address,
    output logic [eetg_pkg::IDX_W-1:0]            event_index,
    output logic                                  gave_up,
    output eetg_pkg::back_status_t                status
);

    localparam int DRAW_W = $clog2(MAX_DRAWS + 1);
    localparam int LIM_W  = $clog2(MAX_EVENTS + 1) > eetg_pkg::POS_W ?
                            $clog2(MAX_EVENTS + 1) : eetg_pkg::POS_W;
    localparam logic [DRAW_W-1:0] LAST_DRAW = DRAW_W'(MAX_DRAWS - 1);
    localparam logic [LIM_W-1:0]  MAX_EV    = LIM_W'(MAX_EVENTS);

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_SQ, S_LN, S_NL, S_MUL, S_CHECK, S_DONE
    } state_t;

    state_t state_reg;

    logic [eetg_pkg::LFSR_W-1:0] lfsr_reg  [NUM_CHANNELS];
    logic [eetg_pkg::TIME_W-1:0] last_reg  [NUM_CHANNELS];
    logic [eetg_pkg::ADDR_W-1:0] blk_reg   [NUM_CHANNELS];
    logic [eetg_pkg::POS_W-1:0]  pos_reg   [NUM_CHANNELS];

    logic [CH_W-1:0]                 ch_reg;
    logic [DRAW_W-1:0]               draws_reg;
    logic [eetg_pkg::EXP_W-1:0]      exp_reg;
    logic [eetg_pkg::MANT_W-1:0]     mant_reg;
    logic [eetg_pkg::FRAC_BITS-1:0]  frac_reg;
    logic [3:0]                      iter_reg;
    logic [eetg_pkg::LN_W-1:0]       ln_reg;
    logic [eetg_pkg::LN_W-1:0]       nl_reg;
    logic [eetg_pkg::PROD_W-1:0]     prod_reg;
    logic                            ok_reg;
    logic                            out_valid_reg;
    logic [eetg_pkg::TIME_W-1:0]     ts_reg;
    logic [eetg_pkg::ADDR_W-1:0]     first_reg;
    logic [eetg_pkg::ADDR_W-1:0]     second_reg;
    logic [eetg_pkg::IDX_W-1:0]      idx_reg;
    logic                            gave_up_reg;

    logic [eetg_pkg::LFSR_W-1:0] cur_s;
    logic [eetg_pkg::LFSR_W-1:0] step_s;
    logic [eetg_pkg::EXP_W-1:0]  lead;
    logic [63:0]                 sq;
    logic [eetg_pkg::MANT_W-1:0] sq_t;
    logic [35:0]                 ln_p;
    logic [23:0]                 gap;
    logic [eetg_pkg::ADDR_W-1:0] blk_first;
    logic [eetg_pkg::ADDR_W-1:0] blk_second;
    logic [LIM_W-1:0]            limit;
    logic [LIM_W-1:0]            pos_inc;
    logic                        emit;

    assign cur_s  = lfsr_reg[ch_reg];
    assign step_s = {cur_s[0] ^ cur_s[2] ^ cur_s[3] ^ cur_s[5], cur_s[15:1]};

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < eetg_pkg::LFSR_W; i++)
        begin
            if (step_s[i])
                lead = eetg_pkg::EXP_W'(i);
        end
    end

    // one squaring per cycle gives one fraction bit of log2
    assign sq   = 64'(mant_reg) * 64'(mant_reg);
    assign sq_t = sq[61:30];
    assign ln_p = 36'({exp_reg, frac_reg}) * 36'(eetg_pkg::LN2_Q16) + 36'd32768;
    assign gap  = prod_reg[eetg_pkg::PROD_W-1:16];

    assign blk_first  = (blk_reg[ch_reg] > eetg_pkg::BLOCK_LAST) ? '0 : blk_reg[ch_reg];
    assign blk_second = blk_first + eetg_pkg::BLOCK_STEP;
    assign limit      = (LIM_W'(cfg.event_count) < MAX_EV) ? LIM_W'(cfg.event_count) : MAX_EV;
    assign pos_inc    = LIM_W'(pos_reg[ch_reg]) + LIM_W'(1);

    assign emit    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign q_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            draws_reg     <= '0;
            iter_reg      <= '0;
            ok_reg        <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                lfsr_reg[c] <= eetg_pkg::LFSR_SEED;
                last_reg[c] <= eetg_pkg::START_RESET;
                blk_reg[c]  <= '0;
                pos_reg[c]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
                out_valid_reg <= 1'b0;
            if (cfg.start_load)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                    last_reg[c] <= cfg.start_time;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ch_reg    <= q_ch;
                        draws_reg <= '0;
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    lfsr_reg[ch_reg] <= step_s;
                    if (step_s == '0)
                    begin
                        nl_reg    <= eetg_pkg::LN_FULL;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        exp_reg   <= lead;
                        mant_reg  <= eetg_pkg::MANT_W'(step_s) << (5'd30 - {1'b0, lead});
                        frac_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (sq_t[31])
                    begin
                        mant_reg <= sq_t >> 1;
                        frac_reg <= {frac_reg[eetg_pkg::FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        mant_reg <= sq_t;
                        frac_reg <= {frac_reg[eetg_pkg::FRAC_BITS-2:0], 1'b0};
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15)
                        state_reg <= S_LN;
                end
                S_LN:
                begin
                    ln_reg    <= ln_p[35:16];
                    state_reg <= S_NL;
                end
                S_NL:
                begin
                    nl_reg    <= (ln_reg > eetg_pkg::LN_FULL) ? '0 : eetg_pkg::LN_FULL - ln_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= eetg_pkg::PROD_W'(cfg.mean_interval) *
                                 eetg_pkg::PROD_W'(nl_reg);
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (gap >= 24'(cfg.min_gap))
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (draws_reg == LAST_DRAW)
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        draws_reg <= draws_reg + DRAW_W'(1);
                        state_reg <= S_STEP;
                    end
                end
                S_DONE:
                begin
                    if (emit)
                    begin
                        last_reg[ch_reg] <= last_reg[ch_reg] + eetg_pkg::TIME_W'(gap);
                        blk_reg[ch_reg]  <= blk_second + eetg_pkg::BLOCK_STEP;
                        pos_reg[ch_reg]  <= (pos_inc >= limit) ? '0
                                            : eetg_pkg::POS_W'(pos_inc);
                        ts_reg        <= last_reg[ch_reg] + eetg_pkg::TIME_W'(gap);
                        first_reg     <= blk_first;
                        second_reg    <= blk_second;
                        idx_reg       <= pos_reg[ch_reg][eetg_pkg::IDX_W-1:0];
                        gave_up_reg   <= !ok_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid            = out_valid_reg;
    assign timestamp            = ts_reg;
    assign first_block_address  = first_reg;
    assign second_block_address = second_reg;
    assign event_index          = idx_reg;
    assign gave_up              = gave_up_reg;
    assign status.busy          = (state_reg != S_IDLE);
    assign status.drawing       = (state_reg != S_IDLE) && (state_reg != S_DONE);

endmodule
`default_nettype wire

// File: sv/exponential_event_time_generator.sv
// channel   direction  handshake         payload
// request   in         in_valid/ready    channel
// result    out        out_valid/ready   timestamp, block addresses, event_index, gave_up
// config    in         apb write/read    mean, min gap, event count, start time
//
// each draw is an lfsr step, 16 squarings in one shared multiplier for log2,
// ln scale, negate, mean multiply and compare; an item takes one to
// MAX_DRAWS draws plus the done and idle hand-off states. rst_n loads lfsr seeds and
// per-channel state at once. a two-entry request queue lets requests arrive while
// a draw runs; a held result stalls only the final write-back.
`default_nettype none
module exponential_event_time_generator #(
    parameter int NUM_CHANNELS = 3,
    parameter int MAX_DRAWS = 64,
    parameter int MAX_EVENTS = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [eetg_pkg::CHAN_W-1:0]          channel,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [eetg_pkg::TIME_W-1:0]               timestamp,
    output logic [eetg_pkg::ADDR_W-1:0]               first_block_address,
    output logic [eetg_pkg::ADDR_W-1:0]               second_block_address,
    output logic [eetg_pkg::IDX_W-1:0]                event_index,
    output logic                                      gave_up,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [eetg_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [eetg_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [eetg_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [eetg_pkg::MEAN_W-1:0]  mean_reg;
    logic [eetg_pkg::GAP_W-1:0]   min_reg;
    logic [eetg_pkg::COUNT_W-1:0] count_reg;
    logic [eetg_pkg::TIME_W-1:0]  start_reg;
    logic                         wr_en;
    logic [1:0]                   reg_sel;
    eetg_pkg::cfg_t               cfg;
    eetg_pkg::back_status_t       status;
    logic                         q_valid;
    logic                         q_ready;
    logic [CH_W-1:0]              q_ch;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= eetg_pkg::MEAN_RESET;
            min_reg   <= eetg_pkg::MIN_RESET;
            count_reg <= eetg_pkg::COUNT_RESET;
            start_reg <= eetg_pkg::START_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                eetg_pkg::REG_MEAN:  mean_reg  <= pwdata[eetg_pkg::MEAN_W-1:0];
                eetg_pkg::REG_MIN:   min_reg   <= pwdata[eetg_pkg::GAP_W-1:0];
                eetg_pkg::REG_COUNT: count_reg <= pwdata[eetg_pkg::COUNT_W-1:0];
                eetg_pkg::REG_START: start_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            eetg_pkg::REG_MEAN:  prdata = 32'(mean_reg);
            eetg_pkg::REG_MIN:   prdata = 32'(min_reg);
            eetg_pkg::REG_COUNT: prdata = 32'(count_reg);
            eetg_pkg::REG_START: prdata = start_reg;
            default:             prdata = '0;
        endcase
    end

    assign cfg.mean_interval = mean_reg;
    assign cfg.min_gap       = min_reg;
    assign cfg.event_count   = count_reg;
    assign cfg.start_load    = wr_en && (reg_sel == eetg_pkg::REG_START);
    assign cfg.start_time    = pwdata;

    eetg_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .channel  (channel),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_ch     (q_ch)
    );

    eetg_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_DRAWS    (MAX_DRAWS),
        .MAX_EVENTS   (MAX_EVENTS),
        .CH_W         (CH_W)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .q_valid              (q_valid),
        .q_ready              (q_ready),
        .q_ch                 (q_ch),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .timestamp            (timestamp),
        .first_block_address  (first_block_address),
        .second_block_address (second_block_address),
        .event_index          (event_index),
        .gave_up              (gave_up),
        .status               (status)
    );

`ifndef SYNTHESIS
    a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid)
        else $error("queue full but empty");
    a_pop_starts_back: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> status.busy && status.drawing)
        else $error("popped item not started");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> !status.busy)
        else $error("queue popped while busy");
`endif

endmodule
`default_nettype wire
